@@ rtl/fqmm_pkg.sv @@
// fqmm_pkg: shared types and codes for the fifo queue with min/max search
`timescale 1ns / 1ps
package fqmm_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MAX   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MIN   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FIND  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

endpackage

@@ rtl/fqmm_cell.sv @@
// fqmm_cell: one storage cell of the queue chain, position IDX from the oldest entry
`timescale 1ns / 1ps
module fqmm_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0
) (
  input  logic                                clk,
  input  fqmm_pkg::cell_op_t                  op,
  input  logic [$clog2(DEPTH+1)-1:0]          count,
  input  logic signed [fqmm_pkg::DATA_W-1:0]  push_data,
  input  logic signed [fqmm_pkg::DATA_W-1:0]  next_data,
  input  logic signed [fqmm_pkg::DATA_W-1:0]  first_data,
  output logic signed [fqmm_pkg::DATA_W-1:0]  data
);
  import fqmm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_IDX1 = CW'(IDX + 1);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD: begin
        if (count == MY_IDX) begin
          data <= push_data;
        end
      end
      CELL_SHIFT: begin
        data <= next_data;
      end
      CELL_ROTATE: begin
        // the tail cell takes the oldest entry, cells before it move down
        if (count == MY_IDX1) begin
          data <= first_data;
        end else if (MY_IDX1 < count) begin
          data <= next_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

@@ rtl/fifo_queue_with_min_max_search.sv @@
// fifo_queue_with_min_max_search: bounded fifo in a chain of cells with dump, min/max and find
`timescale 1ns / 1ps
// push, pop, clear and empty-queue requests: result in the cycle after the request is taken,
// unknown requests give no result; one request per cycle when the output does not stall
// dump, max and min rotate the chain once, one entry per cycle while the output is not stalled;
// no new request is taken until the scan is done
// find adds a flush state for the final or not-found result
// reset empties the queue and drops any pending result; cell contents are not cleared
module fifo_queue_with_min_max_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] item, [36:32] position, [39:37] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);
  import fqmm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [REQ_W-1:0]     req, req_next;
  logic signed [DATA_W-1:0] key, key_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic [POS_W-1:0]     pend_pos, pend_pos_next;
  logic                 have_pend, have_pend_next;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic signed [DATA_W-1:0] out_item;
  logic [POS_W-1:0]     out_pos;
  logic                 out_last;

  logic                 emit;
  logic [STATUS_W-1:0]  e_status;
  logic signed [DATA_W-1:0] e_item;
  logic [POS_W-1:0]     e_pos;
  logic                 e_last;

  cell_op_t             cell_op;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] first;
  logic signed [DATA_W-1:0] in_value;
  logic [REQ_W-1:0]     in_req;
  logic                 can_emit, accept;
  logic [CW-1:0]        idx_p1;
  logic                 is_end, match;
  logic signed [DATA_W-1:0] best_step;

  // chain of cells, cell 0 holds the oldest entry whenever no scan is running
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] nbr;
    if (g == DEPTH - 1) begin : g_tail
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    fqmm_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .count     (count),
      .push_data (in_value),
      .next_data (nbr),
      .first_data(first),
      .data      (cell_data[g])
    );
  end

  assign first    = cell_data[0];
  assign in_value = s_axis_tdata;
  assign in_req   = s_axis_tuser;
  assign can_emit = !out_valid || m_axis_tready;
  assign s_axis_tready = !rst && (state == S_IDLE) && can_emit;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign idx_p1   = idx + CW'(1);
  assign is_end   = (idx_p1 == count);
  assign match    = (first == key);

  always_comb begin
    if (idx == '0) begin
      best_step = first;
    end else if (req == REQ_MAX) begin
      best_step = (first > best) ? first : best;
    end else begin
      best_step = (first < best) ? first : best;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    req_next       = req;
    key_next       = key;
    best_next      = best;
    pend_pos_next  = pend_pos;
    have_pend_next = have_pend;
    cell_op        = CELL_HOLD;
    emit           = 1'b0;
    e_status       = ST_OK;
    e_item         = '0;
    e_pos          = '0;
    e_last         = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req_next       = in_req;
          key_next       = in_value;
          idx_next       = '0;
          have_pend_next = 1'b0;
          case (in_req)
            REQ_PUSH: begin
              emit   = 1'b1;
              e_item = in_value;
              if (count == FULL_COUNT) begin
                e_status = ST_FULL;
              end else begin
                cell_op    = CELL_LOAD;
                count_next = count + CW'(1);
              end
            end
            REQ_CLEAR: begin
              emit       = 1'b1;
              count_next = '0;
            end
            REQ_POP, REQ_DUMP, REQ_MAX, REQ_MIN, REQ_FIND: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = ST_EMPTY;
              end else if (in_req == REQ_POP) begin
                e_item     = first;
                cell_op    = CELL_SHIFT;
                count_next = count - CW'(1);
              end else begin
                emit       = 1'b0;
                state_next = S_SCAN;
              end
            end
            default: begin
              // unknown request: no result, no change
            end
          endcase
        end
      end
      S_SCAN: begin
        if (can_emit) begin
          cell_op  = CELL_ROTATE;
          idx_next = idx_p1;
          best_next = best_step;
          if (req == REQ_DUMP) begin
            emit   = 1'b1;
            e_item = first;
            e_pos  = POS_W'(idx_p1);
            e_last = is_end;
          end else if (req == REQ_FIND) begin
            // hold each match back one step so the final one can carry last
            if (match) begin
              emit           = have_pend;
              e_item         = key;
              e_pos          = pend_pos;
              e_last         = 1'b0;
              pend_pos_next  = POS_W'(idx_p1);
              have_pend_next = 1'b1;
            end
          end else begin
            emit   = is_end;
            e_item = best_step;
          end
          if (is_end) begin
            state_next = (req == REQ_FIND) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_item     = key;
          e_pos      = have_pend ? pend_pos : '0;
          e_status   = have_pend ? ST_OK : ST_NOTFOUND;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      have_pend <= have_pend_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    idx      <= idx_next;
    req      <= req_next;
    key      <= key_next;
    best     <= best_next;
    pend_pos <= pend_pos_next;
    if (emit) begin
      out_status <= e_status;
      out_item   <= e_item;
      out_pos    <= e_pos;
      out_last   <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - POS_W)'(0), out_pos, out_item};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx < count))
    else $error("scan index past live entries");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (count == $past(count)))
    else $error("queue count changed during scan");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && in_req == REQ_PUSH && count != FULL_COUNT) |=>
    (count == $past(count) + CW'(1)))
    else $error("push did not grow the queue");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("request taken during scan");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the fifo queue with min/max search
`timescale 1ns / 1ps
module tb_top;
  import fqmm_pkg::*;

  localparam int unsigned DEPTH = 16;
  // the one request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   item;
    logic [POS_W-1:0]    position;
    logic                last;
  } queue_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [2:0]  s_axis_tuser = '0;   // [2:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] item, [36:32] position, [39:37] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        m_axis_tlast;

  // mirror of the queue contents
  logic [DATA_W-1:0] mirror_slots [DEPTH];
  int unsigned       mirror_head = 0;
  int unsigned       mirror_count = 0;
  queue_reply_t      awaited_replies [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_taken = 0;
  int ignored_taken = 0;
  int replies_checked = 0;
  int full_replies = 0;
  int empty_replies = 0;
  int error_count = 0;

  fifo_queue_with_min_max_search #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void await_reply(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] it,
                                      logic [POS_W-1:0] pos, logic lst);
    queue_reply_t r;
    r.status = st;
    r.item = it;
    r.position = pos;
    r.last = lst;
    awaited_replies.push_back(r);
    if (st == ST_FULL) full_replies++;
    if (st == ST_EMPTY) empty_replies++;
  endfunction

  // updates the mirror and queues the replies one request should cause
  function automatic void predict_queue_replies(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] best;
    logic [DATA_W-1:0] e;
    int unsigned       last_match;
    last_match = 0;
    if (kind == REQ_UNUSED) return;
    if (kind == REQ_PUSH) begin
      if (mirror_count >= DEPTH) begin
        await_reply(ST_FULL, val, '0, 1'b1);
      end else begin
        mirror_slots[(mirror_head + mirror_count) % DEPTH] = val;
        mirror_count++;
        await_reply(ST_OK, val, '0, 1'b1);
      end
      return;
    end
    if (kind == REQ_CLEAR) begin
      mirror_head = 0;
      mirror_count = 0;
      await_reply(ST_OK, '0, '0, 1'b1);
      return;
    end
    if (mirror_count == 0) begin
      await_reply(ST_EMPTY, '0, '0, 1'b1);
      return;
    end
    case (kind)
      REQ_POP: begin
        e = mirror_slots[mirror_head];
        mirror_head = (mirror_head + 1) % DEPTH;
        mirror_count--;
        await_reply(ST_OK, e, '0, 1'b1);
      end
      REQ_DUMP: begin
        for (int i = 0; i < mirror_count; i++)
          await_reply(ST_OK, mirror_slots[(mirror_head + i) % DEPTH], POS_W'(i + 1),
                      (i + 1 == mirror_count));
      end
      REQ_MAX, REQ_MIN: begin
        best = mirror_slots[mirror_head];
        for (int i = 1; i < mirror_count; i++) begin
          e = mirror_slots[(mirror_head + i) % DEPTH];
          if (kind == REQ_MAX ? ($signed(e) > $signed(best)) : ($signed(e) < $signed(best)))
            best = e;
        end
        await_reply(ST_OK, best, '0, 1'b1);
      end
      REQ_FIND: begin
        for (int i = 0; i < mirror_count; i++)
          if (mirror_slots[(mirror_head + i) % DEPTH] == val) last_match = i + 1;
        if (last_match == 0) begin
          await_reply(ST_NOTFOUND, val, '0, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++)
            if (mirror_slots[(mirror_head + i) % DEPTH] == val)
              await_reply(ST_OK, val, POS_W'(i + 1), (i + 1 == last_match));
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : reply_check
    queue_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        error_count++;
        $error("reply with nothing awaited: status %0d item %h position %0d last %0d",
               m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tlast);
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (m_axis_tuser !== want.status) begin
          error_count++;
          $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tuser);
        end
        if (m_axis_tdata[31:0] !== want.item) begin
          error_count++;
          $error("item mismatch: expected %h, got %h", want.item, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[36:32] !== want.position) begin
          error_count++;
          $error("position mismatch: expected %0d, got %0d", want.position,
                 m_axis_tdata[36:32]);
        end
        if (m_axis_tlast !== want.last) begin
          error_count++;
          $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
        end
      end
    end
  end

  // one request, with random idle cycles in front of it
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= val;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_queue_replies(kind, val);
    if (kind == REQ_UNUSED) ignored_taken++;
    else requests_taken++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // mostly duplicates and live entries so that finds hit several positions
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($urandom_range(0, 3)) - 32'd2;
      7:          return 32'h8000_0000;
      8:          return 32'h7fff_ffff;
      default:    return (mirror_count == 0) ? 32'($urandom) :
                    mirror_slots[(mirror_head + $urandom_range(0, mirror_count - 1)) % DEPTH];
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(REQ_POP, 32'd0);
    send_request(REQ_DUMP, 32'd0);
    send_request(REQ_MAX, 32'd0);
    send_request(REQ_MIN, 32'd0);
    send_request(REQ_FIND, 32'hffff_ffff);
    send_request(REQ_UNUSED, 32'h1234_5678);
    send_request(REQ_CLEAR, 32'hdead_beef);
  endtask

  task automatic test_extreme_values();
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'h7fff_ffff);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'h7fff_ffff);
    send_request(REQ_MAX, 32'd0);
    send_request(REQ_MIN, 32'd0);
    send_request(REQ_FIND, 32'h7fff_ffff);
    send_request(REQ_FIND, 32'd12345);
    send_request(REQ_DUMP, 32'd0);
    send_request(REQ_POP, 32'd0);
    send_request(REQ_POP, 32'd0);
  endtask

  // fills the queue past full, then drains it, over and over
  task automatic test_random_traffic(input int n_requests);
    logic [REQ_W-1:0] kind;
    int               r;
    int               taken;
    bit               filling;
    taken = 0;
    filling = 1'b1;
    while (taken < n_requests) begin
      if (mirror_count == 0) filling = 1'b1;
      else if (mirror_count == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 3) kind = REQ_UNUSED;
      else if (r < 6) kind = REQ_CLEAR;
      else if (r < (filling ? 65 : 18)) kind = REQ_PUSH;
      else if (!filling && r < 50) kind = REQ_POP;
      else begin
        case ($urandom_range(0, 4))
          0:       kind = REQ_POP;
          1:       kind = REQ_DUMP;
          2:       kind = REQ_MAX;
          3:       kind = REQ_MIN;
          default: kind = REQ_FIND;
        endcase
      end
      send_request(kind, pick_value());
      if (kind != REQ_UNUSED) taken++;
    end
  endtask

  initial begin
    set_idling(22, 64);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_extreme_values();
    test_random_traffic(118);
    set_idling(64, 22);
    test_random_traffic(118);
    set_idling(0, 0);
    test_random_traffic(118);
    s_axis_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("requests taken: %0d plus %0d ignored codes, replies checked: %0d",
             requests_taken, ignored_taken, replies_checked);
    $display("full-queue pushes: %0d, empty-queue replies: %0d", full_replies, empty_replies);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d replies still awaited", awaited_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
